/* rtl/core/srsg_pkg.sv */
// Shared types and constants for the stepper ramp step generator.
// No dependencies; imported by the top level, srsg_apb_regs and srsg_motion.
package srsg_pkg;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_MOVE     = 2'd1,
    KIND_TABLE_WR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_FIRST    = 2'd0,
    REG_CRUISE   = 2'd1,
    REG_RAMP_LEN = 2'd2
  } reg_idx_e;

  localparam int unsigned IntervalW = 24;
  localparam int unsigned RampW     = 10;
  localparam logic [RampW-1:0] RampMax = {RampW{1'b1}};

  typedef struct packed {
    logic [IntervalW-1:0] first_interval;
    logic [IntervalW-1:0] cruise_interval;
    logic [RampW-1:0]     ramp_length;
  } cfg_t;

  // Input item; tdata carries table_value, table_index, target_position (high to low)
  typedef struct packed {
    logic [1:0]           kind;
    logic [IntervalW-1:0] table_value;
    logic [8:0]           table_index;
    logic [31:0]          target_position;
  } item_t;

  // Result item; packed so step_pulse lands in bit 0
  typedef struct packed {
    logic        moving;
    logic [31:0] distance_to_go;
    logic [31:0] position;
    logic        step_direction;
    logic        step_pulse;
  } result_t;

endpackage

/* rtl/core/stepper_ramp_step_generator.sv */
// Top level of the stepper ramp step generator.
// Depends on srsg_pkg, srsg_apb_regs, srsg_ram and srsg_motion.
//
// Usage:
//   s_axis carries one item per transfer. tuser is the kind: tick (one
//   microsecond), move to target, or ramp table write. Table writes land in
//   the ramp RAM as the item is accepted; load the table before moving.
//   m_axis returns exactly one result item per input item, in order.
//   The APB port sets first interval (0x0), cruise interval (0x4) and ramp
//   length (0x8); write it only while no item is in flight.
// Flow:
//   An item passes through the input stage, then the result register; one item per
//   cycle is sustained while m_axis_tready_i is high. The input stage holds an item
//   while the ramp RAM is read at the ramp index it will see, so the table value is
//   ready when the speed update runs.
// Reset:
//   Motion state is cleared at once; the ramp table has no clearing pass and
//   holds garbage until written. No item is taken during reset.
// Stall:
//   The result register holds while m_axis_tready_i is low; the input stage
//   keeps accepting until it is full, then s_axis_tready_o drops.
module stepper_ramp_step_generator
  import srsg_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] target_position, [40:32] table_index, [64:41] table_value
  input  logic [71:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] step_pulse, [1] step_direction, [33:2] position,
  // [65:34] distance_to_go, [66] moving
  output logic [71:0] m_axis_tdata_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CmpW  = 13;

  cfg_t                 cfg;
  item_t                in_item, s1_item_q;
  logic                 s1_valid_q, out_valid_q, run_q;
  logic                 accept, exec;
  result_t              result, out_q;
  logic [RampW-1:0]     ramp_next;
  logic [AddrW-1:0]     rd_addr;
  logic [IntervalW-1:0] rd_data;
  logic                 tbl_we;

  srsg_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign in_item = {s_axis_tuser_i, s_axis_tdata_i[64:0]};

  assign exec            = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  // input opens the cycle after reset is released
  assign s_axis_tready_o = run_q && (!s1_valid_q || exec);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // entries past the table depth are dropped
  assign tbl_we = accept && (in_item.kind == KIND_TABLE_WR)
               && ({{(CmpW-9){1'b0}}, in_item.table_index} < CmpW'(TABLE_DEPTH));

  // ramp index beyond the table reads the last entry
  always_comb begin
    if ({{(CmpW-RampW){1'b0}}, ramp_next} > CmpW'(TABLE_DEPTH - 1)) begin
      rd_addr = AddrW'(TABLE_DEPTH - 1);
    end else begin
      rd_addr = AddrW'(ramp_next);
    end
  end

  srsg_ram #(
    .WIDTH(IntervalW),
    .DEPTH(TABLE_DEPTH)
  ) u_ramp_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(AddrW'(in_item.table_index)),
    .wdata_i(in_item.table_value),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  srsg_motion u_motion (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .exec_i        (exec),
    .item_i        (s1_item_q),
    .cfg_i         (cfg),
    .table_rd_i    (rd_data),
    .result_o      (result),
    .ramp_index_d_o(ramp_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= 1'b1;
      s1_valid_q  <= accept || (s1_valid_q && !exec);
      out_valid_q <= exec || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_item_q <= in_item;
    if (exec)   out_q     <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

endmodule

/* rtl/core/srsg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsg_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/srsg_apb_regs.sv */
// APB configuration registers: first interval, cruise interval, ramp length.
// Depends on srsg_pkg.
module srsg_apb_regs
  import srsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_FIRST:    cfg_d.first_interval  = pwdata[IntervalW-1:0];
        REG_CRUISE:   cfg_d.cruise_interval = pwdata[IntervalW-1:0];
        REG_RAMP_LEN: cfg_d.ramp_length     = pwdata[RampW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FIRST:    prdata = {8'd0, cfg_q.first_interval};
      REG_CRUISE:   prdata = {8'd0, cfg_q.cruise_interval};
      REG_RAMP_LEN: prdata = {22'd0, cfg_q.ramp_length};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/srsg_motion.sv */
// Motion state and speed update: position, goal, ramp index, flags, interval.
// Depends on srsg_pkg; table data comes from the ramp RAM, read at the ramp index this update will see.
module srsg_motion
  import srsg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 exec_i,
  input  item_t                item_i,
  input  cfg_t                 cfg_i,
  input  logic [IntervalW-1:0] table_rd_i,
  output result_t              result_o,
  output logic [RampW-1:0]     ramp_index_d_o
);

  logic [31:0]          pos_q, pos_d, goal_q, goal_d;
  logic [RampW-1:0]     ramp_q, ramp_d;
  logic                 accel_q, accel_d, dir_q, dir_d;
  logic [IntervalW-1:0] interval_q, interval_d;
  logic [31:0]          elapsed_q, elapsed_d, elapsed_inc;

  logic        step, do_update, positive, negative, same_way, ramp_ge_mag, accel_n;
  logic [31:0] diff, mag;

  assign elapsed_inc = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;
  assign step = (item_i.kind == KIND_TICK) && (interval_q != '0)
             && (elapsed_inc >= {8'd0, interval_q});

  assign pos_d  = step ? (dir_q ? pos_q + 32'd1 : pos_q - 32'd1) : pos_q;
  assign goal_d = (item_i.kind == KIND_MOVE) ? item_i.target_position : goal_q;
  assign diff   = goal_d - pos_d;

  assign negative    = diff[31];
  assign positive    = (diff != 32'd0) && !diff[31];
  assign mag         = negative ? (32'd0 - diff) : diff;
  assign same_way    = (dir_q == positive);
  assign ramp_ge_mag = (mag[31:RampW] == '0) && (ramp_q >= mag[RampW-1:0]);
  assign do_update   = step || (item_i.kind == KIND_MOVE);

  always_comb begin
    accel_n = accel_q;
    if (diff != 32'd0) begin
      if (accel_q) begin
        if (ramp_ge_mag || !same_way) accel_n = 1'b0;
      end else begin
        if (!ramp_ge_mag && same_way) accel_n = 1'b1;
      end
    end
  end

  always_comb begin
    ramp_d     = ramp_q;
    accel_d    = accel_q;
    dir_d      = dir_q;
    interval_d = interval_q;
    elapsed_d  = (item_i.kind == KIND_TICK) ? elapsed_inc : elapsed_q;
    if (step) elapsed_d = 32'd0;
    if (do_update) begin
      if ((diff == 32'd0) && (ramp_q <= RampW'(1))) begin
        // at target and slow enough: stop
        interval_d = '0;
        ramp_d     = '0;
      end else begin
        accel_d = accel_n;
        if (ramp_q == '0) begin
          interval_d = cfg_i.first_interval;
          dir_d      = positive;
          ramp_d     = RampW'(1);
        end else if (ramp_q == cfg_i.ramp_length) begin
          interval_d = cfg_i.cruise_interval;
          if (!accel_n) ramp_d = ramp_q - RampW'(1);
        end else begin
          interval_d = table_rd_i;
          if (accel_n) begin
            if (ramp_q != RampMax) ramp_d = ramp_q + RampW'(1);
          end else begin
            ramp_d = ramp_q - RampW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      goal_q     <= '0;
      ramp_q     <= '0;
      accel_q    <= 1'b0;
      dir_q      <= 1'b0;
      interval_q <= '0;
      elapsed_q  <= 32'hFFFF_FFFF;
    end else if (exec_i) begin
      pos_q      <= pos_d;
      goal_q     <= goal_d;
      ramp_q     <= ramp_d;
      accel_q    <= accel_d;
      dir_q      <= dir_d;
      interval_q <= interval_d;
      elapsed_q  <= elapsed_d;
    end
  end

  // ramp index the next item will see; holds while nothing executes
  assign ramp_index_d_o = exec_i ? ramp_d : ramp_q;

  assign result_o.step_pulse     = step;
  assign result_o.step_direction = dir_d;
  assign result_o.position       = pos_d;
  assign result_o.distance_to_go = diff;
  assign result_o.moving         = (interval_d != '0);

endmodule
